[src/nnd_pkg.sv]
package nnd_pkg;

  localparam int MaxDimDefault = 8192;

  localparam int RegW = 14;
  localparam int OutCntW = 13;
  localparam int PixW = 32;
  localparam int RegCount = 4;
  localparam int RegIdxW = $clog2(RegCount);

  typedef enum logic [RegIdxW-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_TGT_WIDTH  = 2'd2,
    REG_TGT_HEIGHT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic pick;
    logic last;
  } nnd_mark_t;

endpackage

[src/nnd_cfg.sv]
module nnd_cfg #(
  parameter int MAX_DIM = nnd_pkg::MaxDimDefault,
  localparam int DimW = $clog2(MAX_DIM + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [nnd_pkg::RegIdxW-1:0] cfg_index,
  input  logic [nnd_pkg::RegW-1:0]    cfg_data,
  output logic [DimW-1:0]             src_w,
  output logic [DimW-1:0]             src_h,
  output logic [DimW-1:0]             tgt_w,
  output logic [DimW-1:0]             tgt_h
);
  import nnd_pkg::*;

  function automatic logic [DimW-1:0] clamp_dim(input logic [RegW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DimW'(MAX_DIM);
    end else begin
      r = DimW'(v);
    end
    return r;
  endfunction

  logic [RegW-1:0] raw_sw, raw_sh, raw_tw, raw_th;
  logic [RegW-1:0] raw_sw_next, raw_sh_next, raw_tw_next, raw_th_next;
  logic [DimW-1:0] sw_c, sh_c, tw_c, th_c;

  // The clamped sizes are built from the post-write values, so they are valid
  // at the same edge that stores the register.
  always_comb begin
    raw_sw_next = raw_sw;
    raw_sh_next = raw_sh;
    raw_tw_next = raw_tw;
    raw_th_next = raw_th;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SRC_WIDTH:  raw_sw_next = cfg_data;
        REG_SRC_HEIGHT: raw_sh_next = cfg_data;
        REG_TGT_WIDTH:  raw_tw_next = cfg_data;
        REG_TGT_HEIGHT: raw_th_next = cfg_data;
        default: ;
      endcase
    end
    sw_c = clamp_dim(raw_sw_next);
    sh_c = clamp_dim(raw_sh_next);
    tw_c = clamp_dim(raw_tw_next);
    th_c = clamp_dim(raw_th_next);
    if (tw_c > sw_c) begin
      tw_c = sw_c;
    end
    if (th_c > sh_c) begin
      th_c = sh_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_sw <= RegW'(1);
      raw_sh <= RegW'(1);
      raw_tw <= RegW'(1);
      raw_th <= RegW'(1);
      src_w  <= DimW'(1);
      src_h  <= DimW'(1);
      tgt_w  <= DimW'(1);
      tgt_h  <= DimW'(1);
    end else begin
      raw_sw <= raw_sw_next;
      raw_sh <= raw_sh_next;
      raw_tw <= raw_tw_next;
      raw_th <= raw_th_next;
      src_w  <= sw_c;
      src_h  <= sh_c;
      tgt_w  <= tw_c;
      tgt_h  <= th_c;
    end
  end

endmodule

[src/nnd_walk.sv]
module nnd_walk #(
  parameter int MAX_DIM = nnd_pkg::MaxDimDefault,
  localparam int DimW = $clog2(MAX_DIM + 1),
  localparam int CntW = $clog2(MAX_DIM)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        restart,
  input  logic                        step,
  input  logic [DimW-1:0]             src_w,
  input  logic [DimW-1:0]             src_h,
  input  logic [DimW-1:0]             tgt_w,
  input  logic [DimW-1:0]             tgt_h,
  output nnd_pkg::nnd_mark_t          mark,
  output logic [nnd_pkg::OutCntW-1:0] col,
  output logic [nnd_pkg::OutCntW-1:0] row
);
  import nnd_pkg::*;

  logic [CntW-1:0] src_col, src_row, tgt_col, tgt_row;
  logic [DimW-1:0] col_rem, row_rem;
  logic            col_sel, row_sel, row_done, frame_done;

  always_comb begin
    col_sel    = col_rem < tgt_w;
    row_sel    = row_rem < tgt_h;
    row_done   = (DimW'(src_col) + DimW'(1)) >= src_w;
    frame_done = (DimW'(src_row) + DimW'(1)) >= src_h;
    mark.pick  = col_sel && row_sel;
    mark.last  = (tgt_col == CntW'(tgt_w - DimW'(1))) &&
                 (tgt_row == CntW'(tgt_h - DimW'(1)));
    col        = OutCntW'(tgt_col);
    row        = OutCntW'(tgt_row);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      src_col <= '0;
      src_row <= '0;
      tgt_col <= '0;
      tgt_row <= '0;
      col_rem <= '0;
      row_rem <= '0;
    end else if (step) begin
      if (row_done) begin
        src_col <= '0;
        tgt_col <= '0;
        col_rem <= '0;
        if (frame_done) begin
          src_row <= '0;
          tgt_row <= '0;
          row_rem <= '0;
        end else begin
          src_row <= src_row + CntW'(1);
          if (row_sel) begin
            row_rem <= row_rem + src_h - tgt_h;
            tgt_row <= tgt_row + CntW'(1);
          end else begin
            row_rem <= row_rem - tgt_h;
          end
        end
      end else begin
        src_col <= src_col + CntW'(1);
        if (col_sel) begin
          col_rem <= col_rem + src_w - tgt_w;
          tgt_col <= tgt_col + CntW'(1);
        end else begin
          col_rem <= col_rem - tgt_w;
        end
      end
    end
  end

endmodule

[src/nearest_neighbor_downscale.sv]
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  pixel_in
// out       source     out_valid / out_stall pixel_out, out_col, out_row, frame_end
// cfg       sink       cfg_we               cfg_index, cfg_data
//
// One source pixel is taken per cycle while in_stall is low; a chosen pixel
// reaches out_valid through the input register and then the result register.
// Reset is synchronous; sizes return to one and the frame position to zero.
// A stalled result blocks the input only when the waiting input pixel is chosen.
// Any configuration write restarts the frame at source pixel zero.
module nearest_neighbor_downscale #(
  parameter int MAX_DIM = nnd_pkg::MaxDimDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [nnd_pkg::RegIdxW-1:0] cfg_index,
  input  logic [nnd_pkg::RegW-1:0]    cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [nnd_pkg::PixW-1:0]    pixel_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [nnd_pkg::PixW-1:0]    pixel_out,
  output logic [nnd_pkg::OutCntW-1:0] out_col,
  output logic [nnd_pkg::OutCntW-1:0] out_row,
  output logic                        frame_end
);
  import nnd_pkg::*;

  localparam int DimW = $clog2(MAX_DIM + 1);

  logic [DimW-1:0]    src_w, src_h, tgt_w, tgt_h;
  logic               hold_vld;
  logic [PixW-1:0]    hold_pix;
  logic               advance;
  nnd_mark_t          mark;
  logic [OutCntW-1:0] col, row;

  nnd_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src_w     (src_w),
    .src_h     (src_h),
    .tgt_w     (tgt_w),
    .tgt_h     (tgt_h)
  );

  nnd_walk #(.MAX_DIM(MAX_DIM)) u_walk (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_we),
    .step    (advance),
    .src_w   (src_w),
    .src_h   (src_h),
    .tgt_w   (tgt_w),
    .tgt_h   (tgt_h),
    .mark    (mark),
    .col     (col),
    .row     (row)
  );

  assign advance  = hold_vld && (!mark.pick || !out_valid || !out_stall);
  assign in_stall = hold_vld && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        hold_vld <= in_valid;
      end
      if (advance && mark.pick) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      hold_pix <= pixel_in;
    end
    if (advance && mark.pick) begin
      pixel_out <= hold_pix;
      out_col   <= col;
      out_row   <= row;
      frame_end <= mark.last;
    end
  end

endmodule

[src/nnd_checker.sv]
module nnd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_we,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [nnd_pkg::PixW-1:0]    pixel_out,
  input logic [nnd_pkg::OutCntW-1:0] out_col,
  input logic [nnd_pkg::OutCntW-1:0] out_row,
  input logic                        frame_end
);
  import nnd_pkg::*;

  logic               have_prev;
  logic               after_end;
  logic [OutCntW-1:0] prev_col, prev_row;
  logic               out_beat;

  assign out_beat = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      have_prev <= 1'b0;
      after_end <= 1'b0;
    end else if (out_beat) begin
      have_prev <= !frame_end;
      after_end <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) begin
      prev_col <= out_col;
      prev_row <= out_row;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result beat shown right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_out) &&
      $stable(out_col) && $stable(out_row) && $stable(frame_end))
    else $error("Stalled result beat changed.");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid && after_end |-> out_col == '0 && out_row == '0)
    else $error("Frame did not restart at target origin.");

  a_raster_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && have_prev && !cfg_we |->
      (out_row == prev_row && out_col == prev_col + OutCntW'(1)) ||
      (out_row == prev_row + OutCntW'(1) && out_col == '0))
    else $error("Result beats left raster order.");

endmodule

bind nearest_neighbor_downscale nnd_checker u_nnd_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pixel_out (pixel_out),
  .out_col   (out_col),
  .out_row   (out_row),
  .frame_end (frame_end)
);
